// ----- sv/cdr_pkg.sv -----
package cdr_pkg;

  // Ramp length in steps and profile table length.
  localparam int Steps    = 100;
  localparam int TableLen = 100;
  localparam int Q15One   = 32768;

  // Width of the step counter; it must also hold Steps itself.
  localparam int SiW = $clog2(Steps + 1);
  localparam int KW  = $clog2(TableLen);

  // Per-step increments of x = floor(i * 32768 / Steps) and
  // k = floor(i * TableLen / Steps), as quotient and remainder.
  localparam int XQuo = Q15One / Steps;
  localparam int XRem = Q15One % Steps;
  localparam int KQuo = TableLen / Steps;
  localparam int KRem = TableLen % Steps;

  localparam logic [15:0] StepPeriodRst = 16'd10;
  localparam logic signed [8:0] DriveMax = 9'sd255;
  localparam logic signed [8:0] DriveMin = -9'sd255;

  // Direction codes.
  localparam logic [2:0] DirFwd   = 3'd0;
  localparam logic [2:0] DirBwd   = 3'd1;
  localparam logic [2:0] DirRight = 3'd2;
  localparam logic [2:0] DirLeft  = 3'd3;

  // Operands of one drive pair computation.
  typedef struct packed {
    logic [1:0]         dir;
    logic signed [8:0]  tgt;
    logic signed [8:0]  sb;
    logic signed [8:0]  rtb;
    logic signed [8:0]  ltb;
    logic [15:0]        x;
    logic signed [15:0] g;
  } step_op_t;

  // Quarter wave of sin(2 pi k/100)/(2 pi) in Q1.15.
  function automatic logic signed [15:0] quarter_wave(input logic [4:0] i);
    logic signed [15:0] v;
    case (i)
      5'd0:  v = 16'sd0;
      5'd1:  v = 16'sd327;
      5'd2:  v = 16'sd654;
      5'd3:  v = 16'sd977;
      5'd4:  v = 16'sd1297;
      5'd5:  v = 16'sd1612;
      5'd6:  v = 16'sd1920;
      5'd7:  v = 16'sd2221;
      5'd8:  v = 16'sd2512;
      5'd9:  v = 16'sd2794;
      5'd10: v = 16'sd3065;
      5'd11: v = 16'sd3324;
      5'd12: v = 16'sd3570;
      5'd13: v = 16'sd3802;
      5'd14: v = 16'sd4018;
      5'd15: v = 16'sd4219;
      5'd16: v = 16'sd4403;
      5'd17: v = 16'sd4570;
      5'd18: v = 16'sd4719;
      5'd19: v = 16'sd4849;
      5'd20: v = 16'sd4960;
      5'd21: v = 16'sd5051;
      5'd22: v = 16'sd5123;
      5'd23: v = 16'sd5174;
      5'd24: v = 16'sd5205;
      5'd25: v = 16'sd5215;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Full-wave profile entry, mirrored from the quarter wave.
  function automatic logic signed [15:0] profile_val(input logic [6:0] k);
    logic signed [15:0] v;
    if (k <= 7'd25) begin
      v = quarter_wave(k[4:0]);
    end else if (k <= 7'd50) begin
      v = quarter_wave(5'(7'd50 - k));
    end else if (k <= 7'd75) begin
      v = -quarter_wave(5'(k - 7'd50));
    end else if (k <= 7'd99) begin
      v = -quarter_wave(5'(7'd100 - k));
    end else begin
      v = 16'sd0;
    end
    return v;
  endfunction

endpackage

// ----- sv/cdr_rom.sv -----
// Profile table with a registered read port.
module cdr_rom (
  input  logic                     clk_i,
  input  logic [cdr_pkg::KW-1:0]   addr_i,
  output logic signed [15:0]       data_o
);

  logic signed [15:0] data_q;

  // The read data is registered.
  always_ff @(posedge clk_i) begin
    data_q <= cdr_pkg::profile_val(7'(addr_i));
  end

  assign data_o = data_q;

endmodule

// ----- sv/cdr_drive.sv -----
// Computes one drive pair: base * 32768 + delta * cycloid, truncated toward
// zero and saturated.
module cdr_drive (
  input  cdr_pkg::step_op_t  op_i,
  output logic signed [8:0]  left_o,
  output logic signed [8:0]  right_o
);

  logic signed [17:0] c_w;
  logic signed [17:0] h_w;
  logic signed [17:0] opnd_w;
  logic signed [10:0] br_w;
  logic signed [10:0] bl_w;
  logic signed [10:0] mr_w;
  logic signed [10:0] ml_w;
  logic signed [31:0] sr_w;
  logic signed [31:0] sl_w;

  // Truncate a Q.15 value toward zero and clamp to the drive range.
  function automatic logic signed [8:0] to_drive(input logic signed [31:0] s);
    logic signed [16:0] q;
    q = 17'(s >>> 15);
    if (s[31] && (s[14:0] != 15'd0)) begin
      q = q + 17'sd1;
    end
    if (q > 17'sd255) begin
      return cdr_pkg::DriveMax;
    end else if (q < -17'sd255) begin
      return cdr_pkg::DriveMin;
    end
    return 9'(q);
  endfunction

  // Cycloid and its mirror.
  assign c_w = $signed({2'b00, op_i.x}) - 18'(op_i.g);
  assign h_w = $signed({2'b00, op_i.x}) + 18'(op_i.g);

  // Bases and deltas per direction, with the sign folded into the delta.
  always_comb begin
    br_w   = 11'(op_i.sb);
    bl_w   = 11'(op_i.sb);
    mr_w   = 11'(op_i.tgt) - 11'(op_i.sb);
    ml_w   = 11'(op_i.tgt) - 11'(op_i.sb);
    opnd_w = c_w;
    unique case ({1'b0, op_i.dir})
      cdr_pkg::DirRight: begin
        br_w   = 11'(op_i.sb) + 11'(op_i.rtb);
        bl_w   = 11'(op_i.sb) + 11'(op_i.ltb);
        mr_w   = -(11'(op_i.tgt) + 11'(op_i.rtb));
        ml_w   = 11'(op_i.tgt) - 11'(op_i.ltb);
        opnd_w = h_w;
      end
      cdr_pkg::DirLeft: begin
        br_w   = 11'(op_i.rtb);
        bl_w   = 11'(op_i.ltb);
        mr_w   = 11'(op_i.tgt) - 11'(op_i.rtb);
        ml_w   = -(11'(op_i.tgt) + 11'(op_i.ltb));
        opnd_w = h_w;
      end
      default: begin
      end
    endcase
  end

  // One multiply per wheel, then the base add.
  assign sr_w = (32'(br_w) <<< 15) + 32'(mr_w) * 32'(opnd_w);
  assign sl_w = (32'(bl_w) <<< 15) + 32'(ml_w) * 32'(opnd_w);

  assign right_o = to_drive(sr_w);
  assign left_o  = to_drive(sl_w);

endmodule

// ----- sv/cycloidal_drive_ramp.sv -----
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the output register frees as it drains.
// The step profile comes from a registered table read ahead, at the
// index of the next step, so a step never waits on the table.
// Reset clears all ramp state and the drive pair and sets step_period to 10;
// the profile table is constant and needs no clearing.
module cycloidal_drive_ramp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_period_we_i,
  input  logic [15:0] step_period_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [8:0] target_speed, [11:9] direction
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [8:0] left_drive, [17:9] right_drive,
                                      // [18] drive_updated, [19] busy_res,
                                      // [20] command_rejected
);

  localparam int SiW = cdr_pkg::SiW;
  localparam int KW  = cdr_pkg::KW;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OUT,
    PH_BACK
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [15:0]         period_q;
  logic [1:0]          dir_q, dir_d;
  logic signed [8:0]   tgt_q, tgt_d;
  logic signed [8:0]   sb_q, sb_d;
  logic signed [8:0]   rtb_q, rtb_d;
  logic signed [8:0]   ltb_q, ltb_d;
  logic [SiW-1:0]      si_q, si_d;
  logic [15:0]         x_q, x_d;
  logic [SiW-1:0]      xr_q, xr_d;
  logic [KW-1:0]       k_q, k_d;
  logic [SiW-1:0]      kr_q, kr_d;
  logic [15:0]         tc_q, tc_d;
  logic signed [8:0]   last_l_q, last_l_d;
  logic signed [8:0]   last_r_q, last_r_d;
  logic                out_valid_q;
  logic [23:0]         out_data_q;

  logic                accept_w;
  logic signed [8:0]   tgt_in_w;
  logic [2:0]          dir_in_w;
  logic [15:0]         period_w;
  logic [15:0]         tc_inc_w;
  logic                updated_w;
  logic                rejected_w;
  logic                issue_w;
  logic                restart_w;
  logic [SiW:0]        xr_sum_w;
  logic [SiW:0]        kr_sum_w;
  logic signed [15:0]  g_w;
  logic signed [8:0]   drv_l_w;
  logic signed [8:0]   drv_r_w;
  cdr_pkg::step_op_t   op_w;

  assign accept_w      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign dir_in_w      = s_axis_tdata[11:9];
  assign tgt_in_w      = (s_axis_tdata[8:0] == 9'h100) ? cdr_pkg::DriveMin
                                                       : $signed(s_axis_tdata[8:0]);
  assign period_w      = (period_q == 16'd0) ? 16'd1 : period_q;
  assign tc_inc_w      = tc_q + 16'd1;

  // Profile table, addressed by the index of the step issued next.
  cdr_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (k_d),
    .data_o (g_w)
  );

  cdr_drive u_drive (
    .op_i    (op_w),
    .left_o  (drv_l_w),
    .right_o (drv_r_w)
  );

  // Step sequencing, phase control and operand selection.
  always_comb begin
    phase_d    = phase_q;
    dir_d      = dir_q;
    tgt_d      = tgt_q;
    sb_d       = sb_q;
    rtb_d      = rtb_q;
    ltb_d      = ltb_q;
    si_d       = si_q;
    x_d        = x_q;
    xr_d       = xr_q;
    k_d        = k_q;
    kr_d       = kr_q;
    tc_d       = tc_q;
    last_l_d   = last_l_q;
    last_r_d   = last_r_q;
    updated_w  = 1'b0;
    rejected_w = 1'b0;
    issue_w    = 1'b0;
    restart_w  = 1'b0;
    xr_sum_w   = {1'b0, xr_q} + (SiW + 1)'(cdr_pkg::XRem);
    kr_sum_w   = {1'b0, kr_q} + (SiW + 1)'(cdr_pkg::KRem);

    // Default operands: the pending step of the running ramp.
    op_w.dir = dir_q;
    op_w.tgt = tgt_q;
    op_w.sb  = sb_q;
    op_w.rtb = rtb_q;
    op_w.ltb = ltb_q;
    op_w.x   = x_q;
    op_w.g   = g_w;

    if (accept_w) begin
      if (s_axis_tuser) begin
        if (phase_q != PH_IDLE) begin
          rejected_w = 1'b1;
        end else if (dir_in_w <= cdr_pkg::DirLeft) begin
          // New ramp: its first step has a zero profile.
          dir_d     = dir_in_w[1:0];
          tgt_d     = tgt_in_w;
          phase_d   = PH_OUT;
          op_w.dir  = dir_in_w[1:0];
          op_w.tgt  = tgt_in_w;
          op_w.x    = 16'd0;
          op_w.g    = 16'sd0;
          issue_w   = 1'b1;
          restart_w = 1'b1;
        end else begin
          last_l_d  = 9'sd0;
          last_r_d  = 9'sd0;
          updated_w = 1'b1;
        end
      end else if (phase_q != PH_IDLE) begin
        tc_d = tc_inc_w;
        if (tc_inc_w >= period_w) begin
          tc_d = 16'd0;
          if (32'(si_q) < cdr_pkg::Steps) begin
            issue_w = 1'b1;
            // Advance the step index and its x and table positions.
            si_d = si_q + SiW'(1);
            x_d  = x_q + 16'(cdr_pkg::XQuo);
            xr_d = xr_sum_w[SiW-1:0];
            if (32'(xr_sum_w) >= cdr_pkg::Steps) begin
              x_d  = x_q + 16'(cdr_pkg::XQuo) + 16'd1;
              xr_d = SiW'(32'(xr_sum_w) - cdr_pkg::Steps);
            end
            k_d  = k_q + KW'(cdr_pkg::KQuo);
            kr_d = kr_sum_w[SiW-1:0];
            if (32'(kr_sum_w) >= cdr_pkg::Steps) begin
              k_d  = k_q + KW'(cdr_pkg::KQuo) + KW'(1);
              kr_d = SiW'(32'(kr_sum_w) - cdr_pkg::Steps);
            end
          end else if (dir_q <= cdr_pkg::DirBwd[1:0]) begin
            // End of a straight ramp.
            sb_d    = tgt_q;
            phase_d = PH_IDLE;
          end else begin
            // End of a spin phase: the turn bases take the target.
            if (dir_q == cdr_pkg::DirRight[1:0]) begin
              rtb_d = -tgt_q;
              ltb_d = tgt_q;
            end else begin
              rtb_d = tgt_q;
              ltb_d = -tgt_q;
            end
            if (phase_q == PH_OUT) begin
              phase_d   = PH_BACK;
              tgt_d     = 9'sd0;
              op_w.tgt  = 9'sd0;
              op_w.rtb  = rtb_d;
              op_w.ltb  = ltb_d;
              op_w.x    = 16'd0;
              op_w.g    = 16'sd0;
              issue_w   = 1'b1;
              restart_w = 1'b1;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
      end
    end

    // Step zero was issued: the next step is step one.
    if (restart_w) begin
      si_d = SiW'(1);
      x_d  = 16'(cdr_pkg::XQuo);
      xr_d = SiW'(cdr_pkg::XRem);
      k_d  = KW'(cdr_pkg::KQuo);
      kr_d = SiW'(cdr_pkg::KRem);
      tc_d = 16'd0;
    end

    if (issue_w) begin
      last_l_d  = drv_l_w;
      last_r_d  = drv_r_w;
      updated_w = 1'b1;
    end
  end

  // State, configuration and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      period_q    <= cdr_pkg::StepPeriodRst;
      dir_q       <= 2'd0;
      tgt_q       <= 9'sd0;
      sb_q        <= 9'sd0;
      rtb_q       <= 9'sd0;
      ltb_q       <= 9'sd0;
      si_q        <= '0;
      x_q         <= 16'd0;
      xr_q        <= '0;
      k_q         <= '0;
      kr_q        <= '0;
      tc_q        <= 16'd0;
      last_l_q    <= 9'sd0;
      last_r_q    <= 9'sd0;
      out_valid_q <= 1'b0;
      out_data_q  <= 24'd0;
    end else begin
      if (step_period_we_i) begin
        period_q <= step_period_i;
      end
      phase_q  <= phase_d;
      dir_q    <= dir_d;
      tgt_q    <= tgt_d;
      sb_q     <= sb_d;
      rtb_q    <= rtb_d;
      ltb_q    <= ltb_d;
      si_q     <= si_d;
      x_q      <= x_d;
      xr_q     <= xr_d;
      k_q      <= k_d;
      kr_q     <= kr_d;
      tc_q     <= tc_d;
      last_l_q <= last_l_d;
      last_r_q <= last_r_d;
      if (accept_w) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {3'b000, rejected_w, (phase_d != PH_IDLE), updated_w,
                        last_r_d, last_l_d};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
